// ----- hw/rtl/chr_pkg.sv -----
// shared types and constants for the chained hash record table
package chr_pkg;

  localparam int CFG_W        = 5;
  localparam int KEY_FIELD_W  = 64;
  localparam int GRADE_W      = 8;
  localparam int RESULT_LIMIT = 64;

  localparam logic [CFG_W-1:0] BUCKETS_USED_RESET = 5'd10;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_DELETE,
    ACT_LOOKUP,
    ACT_RANGE
  } chr_action_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_MISS,
    STAT_FULL
  } chr_status_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [KEY_FIELD_W-1:0] record_key;
    logic [GRADE_W-1:0]     record_grade;
    logic [GRADE_W-1:0]     range_low;
    logic [GRADE_W-1:0]     range_high;
  } chr_req_t;

  typedef struct packed {
    chr_status_t            status;
    logic [KEY_FIELD_W-1:0] found_key;
    logic [GRADE_W-1:0]     found_grade;
    logic                   last_result;
  } chr_res_t;

endpackage

// ----- hw/rtl/chr_ifs.sv -----
// request, result and configuration channel interfaces
interface chr_req_if;
  import chr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [KEY_FIELD_W-1:0] record_key;
  logic [GRADE_W-1:0]     record_grade;
  logic [GRADE_W-1:0]     range_low;
  logic [GRADE_W-1:0]     range_high;

  modport source (output valid, action, record_key, record_grade, range_low, range_high,
                  input ready);
  modport sink (input valid, action, record_key, record_grade, range_low, range_high,
                output ready);
endinterface

interface chr_res_if;
  import chr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [KEY_FIELD_W-1:0] found_key;
  logic [GRADE_W-1:0]     found_grade;
  logic                   last_result;

  modport source (output valid, status, found_key, found_grade, last_result, input ready);
  modport sink (input valid, status, found_key, found_grade, last_result, output ready);
endinterface

interface chr_cfg_if;
  import chr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] buckets_used;

  modport source (output valid, buckets_used, input ready);
  modport sink (input valid, buckets_used, output ready);
endinterface

// ----- hw/rtl/chr_hash.sv -----
// bucket hash: byte sum, then remainder by the bucket count, four bits a cycle
module chr_hash #(
  parameter int MAX_BUCKETS = 16,
  parameter int KEY_BYTES   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [8*KEY_BYTES-1:0]        key,
  input  logic [chr_pkg::CFG_W-1:0]     buckets_used,
  output logic                          done,
  output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] bucket
);
  import chr_pkg::*;

  localparam int KEY_W      = 8 * KEY_BYTES;
  localparam int BKT_W      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SUM_W      = $clog2(KEY_BYTES * 255 + 1);
  localparam int HASH_ITERS = (SUM_W + 3) / 4;
  localparam int PAD_W      = HASH_ITERS * 4;
  localparam int IT_W       = (HASH_ITERS > 1) ? $clog2(HASH_ITERS) : 1;
  localparam int MB_W       = $clog2(MAX_BUCKETS + 1);
  localparam int BU_W       = (MB_W > CFG_W) ? MB_W : CFG_W;
  localparam int IDX_W      = (BKT_W > CFG_W) ? BKT_W : CFG_W;

  logic             busy;
  logic [IT_W-1:0]  iter;
  logic [PAD_W-1:0] sum_q;
  logic [CFG_W-1:0] n_q;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] rem_next;
  logic [SUM_W-1:0] sum;
  logic [BU_W-1:0]  bu_ext;
  logic [BU_W-1:0]  n_eff;
  logic [IDX_W-1:0] rem_ext;

  // byte sum of the key
  always_comb begin
    sum = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      sum = sum + SUM_W'(key[8*b +: 8]);
    end
  end

  // zero acts as one, above the bucket array acts as its size
  assign bu_ext = BU_W'(buckets_used);
  always_comb begin
    if (buckets_used == '0) begin
      n_eff = BU_W'(1);
    end else if (bu_ext > BU_W'(MAX_BUCKETS)) begin
      n_eff = BU_W'(MAX_BUCKETS);
    end else begin
      n_eff = bu_ext;
    end
  end

  // four restoring remainder steps, msb first
  always_comb begin
    logic [CFG_W:0]   t;
    logic [CFG_W-1:0] r;
    r = rem;
    t = '0;
    for (int k = 0; k < 4; k++) begin
      t = {r, sum_q[PAD_W-1-k]};
      if (t >= {1'b0, n_q}) begin
        t = t - {1'b0, n_q};
      end
      r = t[CFG_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        iter  <= '0;
        sum_q <= PAD_W'(sum);
        n_q   <= n_eff[CFG_W-1:0];
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        sum_q <= sum_q << 4;
        iter  <= iter + IT_W'(1);
        if (iter == IT_W'(HASH_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_ext = IDX_W'(rem);
  assign bucket  = rem_ext[BKT_W-1:0];

endmodule

// ----- hw/rtl/chr_ctrl.sv -----
// table sequencer with the entry memory and the bucket fill memory
module chr_ctrl #(
  parameter int MAX_BUCKETS  = 16,
  parameter int BUCKET_DEPTH = 4,
  parameter int KEY_BYTES    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  chr_pkg::chr_req_t      req_p,
  output logic                   hash_start,
  output logic [8*KEY_BYTES-1:0] hash_key,
  input  logic                   hash_done,
  input  logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] hash_bucket,
  input  logic                   slot_free,
  output logic                   push,
  output chr_pkg::chr_res_t      push_res
);
  import chr_pkg::*;

  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int ENT_W  = KEY_W + GRADE_W;
  localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int STORE  = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int N_W    = $clog2(RESULT_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_FILL_RD,
    ST_FILL,
    ST_ENT_RD,
    ST_ENT_CHK,
    ST_EMIT
  } state_t;

  state_t             state, state_next;
  chr_action_t        act, act_next;
  logic [KEY_W-1:0]   key_q, key_q_next;
  logic [GRADE_W-1:0] grade_q, grade_q_next;
  logic [GRADE_W-1:0] lo_q, lo_q_next;
  logic [GRADE_W-1:0] hi_q, hi_q_next;
  logic [BKT_W-1:0]   bkt, bkt_next;
  logic [CNT_W-1:0]   cnt_q, cnt_q_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   keep, keep_next;
  logic [N_W-1:0]     nmatch, nmatch_next;
  logic               pend_v, pend_v_next;
  logic [KEY_W-1:0]   pend_key, pend_key_next;
  logic [GRADE_W-1:0] pend_grade, pend_grade_next;
  chr_res_t           res, res_next;

  // entry memory: key and grade per slot
  logic [ENT_W-1:0]  ent_mem [STORE];
  logic              ent_re, ent_we;
  logic [ADDR_W-1:0] ent_ra, ent_wa, base;
  logic [ENT_W-1:0]  ent_wd, ent_rd;
  logic [KEY_W-1:0]  ent_key;
  logic [GRADE_W-1:0] ent_grade;

  // fill count memory, one valid bit per bucket stands for the cleared reset value
  logic [CNT_W-1:0] fill_mem [MAX_BUCKETS];
  logic             fill_vld [MAX_BUCKETS];
  logic             fill_re, fill_we;
  logic [CNT_W-1:0] fill_wd, fill_rd, fill_cnt;

  assign base      = ADDR_W'(bkt) * ADDR_W'(BUCKET_DEPTH);
  assign ent_ra    = base + ADDR_W'(idx);
  assign ent_key   = ent_rd[ENT_W-1:GRADE_W];
  assign ent_grade = ent_rd[GRADE_W-1:0];
  assign fill_cnt  = fill_vld[bkt] ? fill_rd : '0;
  assign hash_key  = req_p.record_key[KEY_W-1:0];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      ent_rd <= ent_mem[ent_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[bkt] <= fill_wd;
    end
    if (fill_re) begin
      fill_rd <= fill_mem[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < MAX_BUCKETS; b++) begin
        fill_vld[b] <= 1'b0;
      end
    end else if (fill_we) begin
      fill_vld[bkt] <= 1'b1;
    end
  end

  always_comb begin
    state_next      = state;
    act_next        = act;
    key_q_next      = key_q;
    grade_q_next    = grade_q;
    lo_q_next       = lo_q;
    hi_q_next       = hi_q;
    bkt_next        = bkt;
    cnt_q_next      = cnt_q;
    idx_next        = idx;
    keep_next       = keep;
    nmatch_next     = nmatch;
    pend_v_next     = pend_v;
    pend_key_next   = pend_key;
    pend_grade_next = pend_grade;
    res_next        = res;
    in_ready        = (state == ST_IDLE);
    hash_start      = 1'b0;
    push            = 1'b0;
    push_res        = '0;
    ent_re          = 1'b0;
    ent_we          = 1'b0;
    ent_wa          = base + ADDR_W'(keep);
    ent_wd          = ent_rd;
    fill_re         = 1'b0;
    fill_we         = 1'b0;
    fill_wd         = keep;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act_next     = chr_action_t'(req_p.action);
          key_q_next   = req_p.record_key[KEY_W-1:0];
          grade_q_next = req_p.record_grade;
          lo_q_next    = req_p.range_low;
          hi_q_next    = req_p.range_high;
          if (chr_action_t'(req_p.action) == ACT_RANGE) begin
            bkt_next    = '0;
            nmatch_next = '0;
            pend_v_next = 1'b0;
            state_next  = ST_FILL_RD;
          end else begin
            hash_start = 1'b1;
            state_next = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        if (hash_done) begin
          bkt_next   = hash_bucket;
          state_next = ST_FILL_RD;
        end
      end

      ST_FILL_RD: begin
        fill_re    = 1'b1;
        state_next = ST_FILL;
      end

      ST_FILL: begin
        cnt_q_next = fill_cnt;
        idx_next   = '0;
        keep_next  = '0;
        if (act == ACT_INSERT) begin
          if (fill_cnt == CNT_W'(BUCKET_DEPTH)) begin
            res_next = '{status: STAT_FULL, found_key: '0, found_grade: '0, last_result: 1'b1};
          end else begin
            ent_we   = 1'b1;
            ent_wa   = base + ADDR_W'(fill_cnt);
            ent_wd   = {key_q, grade_q};
            fill_we  = 1'b1;
            fill_wd  = fill_cnt + CNT_W'(1);
            res_next = '{status: STAT_OK, found_key: '0, found_grade: '0, last_result: 1'b1};
          end
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ENT_RD;
        end
      end

      ST_ENT_RD: begin
        if (idx == cnt_q) begin
          case (act)
            ACT_DELETE: begin
              fill_we         = 1'b1;
              fill_wd         = keep;
              res_next        = '{status: STAT_MISS, found_key: '0, found_grade: '0,
                                  last_result: 1'b1};
              if (keep != cnt_q) begin
                res_next.status = STAT_OK;
              end
              state_next = ST_EMIT;
            end
            ACT_LOOKUP: begin
              res_next   = '{status: STAT_MISS, found_key: '0, found_grade: '0,
                             last_result: 1'b1};
              state_next = ST_EMIT;
            end
            ACT_RANGE: begin
              if (bkt == BKT_W'(MAX_BUCKETS - 1)) begin
                if (pend_v) begin
                  res_next = '{status: STAT_OK, found_key: KEY_FIELD_W'(pend_key),
                               found_grade: pend_grade, last_result: 1'b1};
                end else begin
                  res_next = '{status: STAT_MISS, found_key: '0, found_grade: '0,
                               last_result: 1'b1};
                end
                state_next = ST_EMIT;
              end else begin
                bkt_next   = bkt + BKT_W'(1);
                state_next = ST_FILL_RD;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end else begin
          ent_re     = 1'b1;
          state_next = ST_ENT_CHK;
        end
      end

      ST_ENT_CHK: begin
        case (act)
          ACT_LOOKUP: begin
            if (ent_key == key_q) begin
              res_next   = '{status: STAT_OK, found_key: KEY_FIELD_W'(ent_key),
                             found_grade: ent_grade, last_result: 1'b1};
              state_next = ST_EMIT;
            end else begin
              idx_next   = idx + CNT_W'(1);
              state_next = ST_ENT_RD;
            end
          end
          ACT_DELETE: begin
            // survivors slide down to the keep slot, never past the read point
            if (ent_key != key_q) begin
              ent_we    = 1'b1;
              keep_next = keep + CNT_W'(1);
            end
            idx_next   = idx + CNT_W'(1);
            state_next = ST_ENT_RD;
          end
          ACT_RANGE: begin
            if (ent_grade >= lo_q && ent_grade <= hi_q) begin
              if (!(pend_v && !slot_free)) begin
                if (pend_v) begin
                  push     = 1'b1;
                  push_res = '{status: STAT_OK, found_key: KEY_FIELD_W'(pend_key),
                               found_grade: pend_grade, last_result: 1'b0};
                end
                if (nmatch == N_W'(RESULT_LIMIT - 1)) begin
                  res_next   = '{status: STAT_OK, found_key: KEY_FIELD_W'(ent_key),
                                 found_grade: ent_grade, last_result: 1'b1};
                  state_next = ST_EMIT;
                end else begin
                  pend_v_next     = 1'b1;
                  pend_key_next   = ent_key;
                  pend_grade_next = ent_grade;
                  nmatch_next     = nmatch + N_W'(1);
                  idx_next        = idx + CNT_W'(1);
                  state_next      = ST_ENT_RD;
                end
              end
            end else begin
              idx_next   = idx + CNT_W'(1);
              state_next = ST_ENT_RD;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_EMIT: begin
        if (slot_free) begin
          push       = 1'b1;
          push_res   = res;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      pend_v <= pend_v_next;
    end
    act        <= act_next;
    key_q      <= key_q_next;
    grade_q    <= grade_q_next;
    lo_q       <= lo_q_next;
    hi_q       <= hi_q_next;
    bkt        <= bkt_next;
    cnt_q      <= cnt_q_next;
    idx        <= idx_next;
    keep       <= keep_next;
    nmatch     <= nmatch_next;
    pend_key   <= pend_key_next;
    pend_grade <= pend_grade_next;
    res        <= res_next;
  end

  a_push_slot : assert property (@(posedge clk) disable iff (rst) push |-> slot_free)
    else $error("result pushed into an occupied output slot");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill_we |-> fill_wd <= CNT_W'(BUCKET_DEPTH))
    else $error("fill count written above bucket depth");

  a_hash_wait : assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == ST_HASH)
    else $error("hash finished while sequencer not waiting");

  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    (push && push_res.last_result) |=> in_ready)
    else $error("final result pushed without returning to idle");

  a_delete_keep : assert property (@(posedge clk) disable iff (rst)
    (state == ST_ENT_CHK && act == ACT_DELETE) |-> keep <= idx)
    else $error("delete compaction overtook the read point");

endmodule

// ----- hw/rtl/chained_hash_record_table.sv -----
// chained hash record table top level: config register, hash unit, sequencer, output register
// request flow: insert, delete and lookup hash the key (load, then four bits of the byte
//   sum a cycle), read the bucket fill count, then insert writes the entry while lookup
//   and delete read and check each bucket entry in turn, lookup only up to the match
// one request at a time: the sequencer takes a new request only while idle
// range query: walks every bucket of the array and each stored entry, up to the result cap
// reset: fill counts read as empty at once (per-bucket valid bits), buckets_used is 10,
//   no clearing pass; the entry memory is not cleared
module chained_hash_record_table #(
  parameter int MAX_BUCKETS  = 16,
  parameter int BUCKET_DEPTH = 4,
  parameter int KEY_BYTES    = 8
) (
  input logic       clk,
  input logic       rst,
  chr_req_if.sink   req,
  chr_res_if.source res,
  chr_cfg_if.sink   cfg
);
  import chr_pkg::*;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  // configuration register; the user must write it only while the table is idle, the block itself does not enforce it
  logic [CFG_W-1:0] buckets_used;

  // request payload bundled for the sequencer
  chr_req_t req_p;

  // hash unit hookup
  logic             hash_start;
  logic [KEY_W-1:0] hash_key;
  logic             hash_done;
  logic [BKT_W-1:0] hash_bucket;

  // output register: one result slot between the sequencer and the consumer
  logic     out_valid;
  chr_res_t out_res;
  logic     slot_free;
  logic     push;
  chr_res_t push_res;
  logic     in_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buckets_used <= BUCKETS_USED_RESET;
    end else if (cfg.valid) begin
      buckets_used <= cfg.buckets_used;
    end
  end

  assign req_p = '{action: req.action, record_key: req.record_key,
                   record_grade: req.record_grade, range_low: req.range_low,
                   range_high: req.range_high};
  assign req.ready = in_ready;

  // bucket index: byte sum, then remainder by the clamped bucket count
  chr_hash #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_hash (
    .clk          (clk),
    .rst          (rst),
    .start        (hash_start),
    .key          (hash_key),
    .buckets_used (buckets_used),
    .done         (hash_done),
    .bucket       (hash_bucket)
  );

  // sequencer owns both memories and does the read, modify, write back
  chr_ctrl #(
    .MAX_BUCKETS  (MAX_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .KEY_BYTES    (KEY_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (in_ready),
    .req_p       (req_p),
    .hash_start  (hash_start),
    .hash_key    (hash_key),
    .hash_done   (hash_done),
    .hash_bucket (hash_bucket),
    .slot_free   (slot_free),
    .push        (push),
    .push_res    (push_res)
  );

  // slot frees up in the same cycle the consumer takes the held result
  assign slot_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      out_res <= push_res;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_res.status;
  assign res.found_key   = out_res.found_key;
  assign res.found_grade = out_res.found_grade;
  assign res.last_result = out_res.last_result;

endmodule

// ----- sim/chained_hash_record_table_tb.sv -----
// self-checking testbench for the chained hash record table
module chained_hash_record_table_tb;
  import chr_pkg::*;

  localparam int TBL_BUCKETS = 16;
  localparam int TBL_DEPTH   = 4;
  localparam int TBL_SIZE    = TBL_BUCKETS * TBL_DEPTH;
  localparam int KEY_POOL_N  = 16;
  localparam int PHASE_N     = 8;

  logic clk;
  logic rst;

  chr_req_if req ();
  chr_res_if res ();
  chr_cfg_if cfg ();

  chained_hash_record_table #(
    .MAX_BUCKETS (TBL_BUCKETS),
    .BUCKET_DEPTH(TBL_DEPTH),
    .KEY_BYTES   (8)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  // shadow copy of the table contents and the bucket count register
  logic [KEY_FIELD_W-1:0] shadow_key [TBL_SIZE];
  logic [GRADE_W-1:0]     shadow_grade [TBL_SIZE];
  int unsigned            shadow_fill [TBL_BUCKETS];
  logic [CFG_W-1:0]       shadow_buckets;

  // requests still to be offered, and replies the table owes us in order
  chr_req_t ops_to_send[$];
  chr_res_t replies_due[$];

  // keys reused across requests so lookups and deletes actually hit
  logic [KEY_FIELD_W-1:0] key_pool [KEY_POOL_N];

  int unsigned n_offered = 0;
  int unsigned n_taken   = 0;
  int unsigned n_fail    = 0;
  bit          hold_off  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous watchdog, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("chained_hash_record_table test failed");
    $finish;
  end

  // bucket index: byte sum of the key modulo the clamped bucket count
  function automatic int unsigned bucket_for(input logic [KEY_FIELD_W-1:0] k);
    int unsigned sum;
    int unsigned n;
    sum = 0;
    for (int i = 0; i < 8; i++) sum += k[8*i +: 8];
    n = shadow_buckets;
    if (n < 1) n = 1;
    if (n > TBL_BUCKETS) n = TBL_BUCKETS;
    return sum % n;
  endfunction

  // applies one accepted request to the shadow table and queues its replies
  task automatic apply_record_op(input logic [1:0] act, input logic [KEY_FIELD_W-1:0] k,
                                 input logic [GRADE_W-1:0] g, input logic [GRADE_W-1:0] lo,
                                 input logic [GRADE_W-1:0] hi);
    int unsigned b;
    int unsigned base;
    int unsigned cnt;
    int unsigned keep;
    int unsigned nres;
    bit          hit;
    chr_res_t    r;
    b    = bucket_for(k);
    base = b * TBL_DEPTH;
    cnt  = shadow_fill[b];
    r.status      = STAT_OK;
    r.found_key   = '0;
    r.found_grade = '0;
    r.last_result = 1'b1;
    case (chr_action_t'(act))
      ACT_INSERT: begin
        // a full bucket drops the record
        if (cnt >= TBL_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_key[base + cnt]   = k;
          shadow_grade[base + cnt] = g;
          shadow_fill[b]           = cnt + 1;
        end
        replies_due.insert(replies_due.size(), r);
      end
      ACT_DELETE: begin
        // drop every copy of the key, survivors slide down in order
        keep = 0;
        for (int i = 0; i < cnt; i++) begin
          if (shadow_key[base + i] != k) begin
            shadow_key[base + keep]   = shadow_key[base + i];
            shadow_grade[base + keep] = shadow_grade[base + i];
            keep++;
          end
        end
        shadow_fill[b] = keep;
        if (keep == cnt) r.status = STAT_MISS;
        replies_due.insert(replies_due.size(), r);
      end
      ACT_LOOKUP: begin
        // first match in insertion order wins
        hit = 1'b0;
        for (int i = 0; i < cnt; i++) begin
          if (!hit && shadow_key[base + i] == k) begin
            hit           = 1'b1;
            r.found_key   = k;
            r.found_grade = shadow_grade[base + i];
          end
        end
        if (!hit) r.status = STAT_MISS;
        replies_due.insert(replies_due.size(), r);
      end
      default: begin
        // range query walks every bucket regardless of the current count
        nres = 0;
        for (int j = 0; j < TBL_BUCKETS; j++) begin
          for (int i = 0; i < shadow_fill[j]; i++) begin
            if (nres < RESULT_LIMIT && shadow_grade[j*TBL_DEPTH + i] >= lo &&
                shadow_grade[j*TBL_DEPTH + i] <= hi) begin
              r.status      = STAT_OK;
              r.found_key   = shadow_key[j*TBL_DEPTH + i];
              r.found_grade = shadow_grade[j*TBL_DEPTH + i];
              r.last_result = 1'b0;
              replies_due.insert(replies_due.size(), r);
              nres++;
            end
          end
        end
        if (nres == 0) begin
          r.status      = STAT_MISS;
          r.last_result = 1'b1;
          replies_due.insert(replies_due.size(), r);
        end else begin
          replies_due[replies_due.size() - 1].last_result = 1'b1;
        end
      end
    endcase
  endtask

  task automatic push_op(input chr_action_t act, input logic [KEY_FIELD_W-1:0] k,
                         input logic [GRADE_W-1:0] g, input logic [GRADE_W-1:0] lo,
                         input logic [GRADE_W-1:0] hi);
    chr_req_t op;
    op.action       = act;
    op.record_key   = k;
    op.record_grade = g;
    op.range_low    = lo;
    op.range_high   = hi;
    ops_to_send.insert(ops_to_send.size(), op);
  endtask

  // short lower-case ascii key, zero padded above the last letter
  function automatic logic [KEY_FIELD_W-1:0] ascii_key();
    logic [KEY_FIELD_W-1:0] k;
    int unsigned            len;
    k   = '0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(97, 122));
    return k;
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1:    return {$urandom, $urandom};
      2:       return ascii_key();
      default: return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    endcase
  endfunction

  // random mix: mostly pool keys so the buckets fill, hit and drain
  task automatic queue_random_ops(input int count);
    int unsigned            sel;
    logic [GRADE_W-1:0]     lo;
    logic [GRADE_W-1:0]     hi;
    logic [KEY_FIELD_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, KEY_POOL_N - 1)] = pick_key();
      k   = pick_key();
      lo  = 8'($urandom);
      hi  = 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        push_op(ACT_INSERT, k, 8'($urandom), lo, hi);
      end else if (sel < 55) begin
        push_op(ACT_DELETE, k, 8'($urandom), lo, hi);
      end else if (sel < 85) begin
        push_op(ACT_LOOKUP, k, 8'($urandom), lo, hi);
      end else begin
        case ($urandom_range(0, 6))
          0: begin
            lo = 8'd0;
            hi = 8'd255;
          end
          1: ;
          2: begin
            // inverted bounds
            lo = 8'($urandom_range(1, 255));
            hi = 8'($urandom_range(0, lo - 1));
          end
          default: begin
            lo = 8'($urandom_range(0, 200));
            hi = lo + 8'($urandom_range(0, 55));
          end
        endcase
        push_op(ACT_RANGE, k, 8'($urandom), lo, hi);
      end
    end
  endtask

  // with sixteen buckets: five inserts aimed at each bucket fill the table,
  // a full range query then hits the result cap, and deletes clear it again
  task automatic queue_fill_and_drain();
    logic [KEY_FIELD_W-1:0] k;
    logic [KEY_FIELD_W-1:0] aimed [$];
    int unsigned            s;
    for (int b = 0; b < TBL_BUCKETS; b++) begin
      for (int j = 0; j <= TBL_DEPTH; j++) begin
        k = {$urandom, $urandom};
        s = 0;
        for (int i = 1; i < 8; i++) s += k[8*i +: 8];
        k[7:0] = 8'(((b + TBL_BUCKETS - (s % TBL_BUCKETS)) % TBL_BUCKETS) +
                    TBL_BUCKETS * $urandom_range(0, 14));
        aimed.insert(aimed.size(), k);
        push_op(ACT_INSERT, k, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    push_op(ACT_RANGE, '0, 8'($urandom), 8'd0, 8'd255);
    foreach (aimed[i]) push_op(ACT_DELETE, aimed[i], 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_until_idle();
    while (ops_to_send.size() != 0 || n_offered != n_taken || replies_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg.buckets_used <= v;
    cfg.valid        <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    shadow_buckets = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // request driver: bursts of back-to-back requests separated by random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    chr_req_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (n_offered == n_taken) begin
      // previous request gone, free to pick the next step
      if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (ops_to_send.size() > 0) begin
        nxt = ops_to_send.pop_front();
        req.action       <= nxt.action;
        req.record_key   <= nxt.record_key;
        req.record_grade <= nxt.record_grade;
        req.range_low    <= nxt.range_low;
        req.range_high   <= nxt.range_high;
        req.valid        <= 1'b1;
        n_offered++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // result side: ready follows a mode that is picked anew at random once its run ends
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 40;
  int unsigned pattern_tick = 0;

  always @(negedge clk) begin
    if (rst || hold_off) begin
      res.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       res.ready <= 1'b1;
        1:       res.ready <= 1'($urandom_range(0, 1));
        2:       res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= ((pattern_tick % 5) < 3);
      endcase
      pattern_tick++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(30, 150);
      end else begin
        mode_left--;
      end
    end
  end

  // long hold-off on the result side while requests keep coming, so the
  // output register fills and the table has to back-pressure its input
  initial begin
    while (n_taken < 30) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: check results against the oldest reply due, then record new requests
  always @(posedge clk) begin
    chr_res_t due;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (replies_due.size() == 0) begin
          $error("result with nothing due: status %0d key %h grade %0d last %0b",
                 res.status, res.found_key, res.found_grade, res.last_result);
          n_fail++;
        end else begin
          due = replies_due.pop_front();
          if (res.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, res.status);
            n_fail++;
          end
          if (res.found_key !== due.found_key) begin
            $error("found_key: expected %h, got %h", due.found_key, res.found_key);
            n_fail++;
          end
          if (res.found_grade !== due.found_grade) begin
            $error("found_grade: expected %0d, got %0d", due.found_grade, res.found_grade);
            n_fail++;
          end
          if (res.last_result !== due.last_result) begin
            $error("last_result: expected %0b, got %0b", due.last_result, res.last_result);
            n_fail++;
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_record_op(req.action, req.record_key, req.record_grade, req.range_low,
                        req.range_high);
        n_taken++;
      end
    end
  end

  // stimulus sequencing and end of test
  initial begin
    logic [CFG_W-1:0] phase_buckets [PHASE_N];
    int               phase_items [PHASE_N];
    logic [KEY_FIELD_W-1:0] all_ones;
    phase_buckets = '{5'd10, 5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd3, 5'd10};
    phase_items   = '{40, 30, 35, 30, 35, 35, 35, 36};
    all_ones      = '1;

    rst              = 1'b1;
    req.valid        = 1'b0;
    req.action       = ACT_INSERT;
    req.record_key   = '0;
    req.record_grade = '0;
    req.range_low    = '0;
    req.range_high   = '0;
    res.ready        = 1'b0;
    cfg.valid        = 1'b0;
    cfg.buckets_used = '0;

    shadow_buckets = BUCKETS_USED_RESET;
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    for (int i = 0; i < KEY_POOL_N; i++) begin
      case (i % 3)
        0:       key_pool[i] = ascii_key();
        1:       key_pool[i] = {$urandom, $urandom};
        default: key_pool[i] = {32'h0, $urandom} & 64'h0000_0000_00ff_00ff;
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset bucket count of ten:
    // "A", "K", "U" and "_" all land in bucket five, zero and all-ones in bucket zero
    push_op(ACT_LOOKUP, '0, 8'd0, 8'd0, 8'd0);              // empty table miss
    push_op(ACT_RANGE, '0, 8'd0, 8'd0, 8'd255);             // no match on empty table
    push_op(ACT_DELETE, 64'h41, 8'd0, 8'd0, 8'd0);          // delete miss
    push_op(ACT_INSERT, '0, 8'd0, 8'd0, 8'd0);
    push_op(ACT_INSERT, all_ones, 8'd255, 8'd0, 8'd0);
    push_op(ACT_LOOKUP, all_ones, 8'd0, 8'd0, 8'd0);
    push_op(ACT_LOOKUP, '0, 8'd0, 8'd0, 8'd0);              // found, but key and grade zero
    push_op(ACT_INSERT, 64'h41, 8'd10, 8'd0, 8'd0);
    push_op(ACT_INSERT, 64'h4b, 8'd20, 8'd0, 8'd0);
    push_op(ACT_INSERT, 64'h41, 8'd30, 8'd0, 8'd0);         // duplicate key
    push_op(ACT_INSERT, 64'h55, 8'd40, 8'd0, 8'd0);
    push_op(ACT_INSERT, 64'h5f, 8'd50, 8'd0, 8'd0);         // bucket full
    push_op(ACT_LOOKUP, 64'h41, 8'd0, 8'd0, 8'd0);          // first of the two copies
    push_op(ACT_RANGE, '0, 8'd0, 8'd0, 8'd255);
    push_op(ACT_RANGE, '0, 8'd0, 8'd255, 8'd0);             // inverted bounds
    push_op(ACT_RANGE, '0, 8'd0, 8'd20, 8'd20);             // single-grade window
    push_op(ACT_DELETE, 64'h41, 8'd0, 8'd0, 8'd0);          // removes both copies, compacts
    push_op(ACT_LOOKUP, 64'h41, 8'd0, 8'd0, 8'd0);
    push_op(ACT_LOOKUP, 64'h55, 8'd0, 8'd0, 8'd0);
    push_op(ACT_RANGE, '0, 8'd0, 8'd0, 8'd254);
    push_op(ACT_DELETE, all_ones, 8'd0, 8'd0, 8'd0);
    push_op(ACT_INSERT, 64'h8000_0000_0000_0001, 8'd128, 8'd255, 8'd255);
    push_op(ACT_LOOKUP, 64'h8000_0000_0000_0001, 8'd255, 8'd0, 8'd0);

    queue_random_ops(phase_items[0]);

    // later phases change the bucket count with records still held
    for (int p = 1; p < PHASE_N; p++) begin
      wait_until_idle();
      write_bucket_count(phase_buckets[p]);
      if (phase_buckets[p] == 5'd16) queue_fill_and_drain();
      queue_random_ops(phase_items[p]);
    end

    wait_until_idle();
    repeat (200) @(posedge clk);
    if (n_fail == 0) begin
      $display("chained_hash_record_table test passed");
    end else begin
      $display("chained_hash_record_table test failed");
    end
    $finish;
  end

endmodule
